>>> sv/lnws_pkg.sv
// ----------------------------------------------------------------------------
// lnws_pkg
// Shared constants and types of the scaled layer normalization block.
// ----------------------------------------------------------------------------
package lnws_pkg;

  localparam int LANES      = 8;
  localparam int MAX_GROUPS = 64;
  localparam int GRP_W      = $clog2(MAX_GROUPS);
  localparam int CNT_W      = GRP_W + 1;
  localparam int DATA_W     = 16;
  localparam int MEAN_W     = 17;
  localparam int SUM_W      = 26;
  localparam int SQ_W       = 32;
  localparam int SUMSQ_W    = 42;
  localparam int INV_W      = 24;
  localparam int EPS_W      = 32;
  localparam int CFG_W      = 32;
  localparam int VAR_W      = 34;
  localparam int DIVN_W     = 49;
  localparam int DIVD_W     = 34;

  localparam logic       KIND_SCALE     = 1'b0;
  localparam logic       KIND_SAMPLE    = 1'b1;
  localparam logic       CFG_ROW_GROUPS = 1'b0;
  localparam logic       CFG_EPSILON    = 1'b1;
  localparam logic [6:0] RG_RESET       = 7'd64;
  localparam logic [EPS_W-1:0] EPS_RESET = 32'd1;

  typedef logic [LANES-1:0][SQ_W-1:0]   sq_vec_t;
  typedef logic [LANES-1:0][DATA_W-1:0] data_vec_t;

  typedef struct packed {
    logic             row_we;
    logic             scale_we;
    logic [GRP_W-1:0] wr_addr;
    logic [GRP_W-1:0] rd_addr;
  } lane_ctrl_t;

  typedef struct packed {
    logic clear;
    logic add;
  } merge_ctrl_t;

endpackage

>>> sv/lnws_div.sv
// ----------------------------------------------------------------------------
// lnws_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnws_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lnws_pkg::DIVN_W-1:0]   dividend,
  input  logic [lnws_pkg::DIVD_W-1:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [lnws_pkg::DIVN_W-1:0]   quotient
);

  logic [5:0]                    cnt;
  logic [lnws_pkg::DIVD_W-1:0]   rem;
  logic [lnws_pkg::DIVD_W-1:0]   dsr;
  logic [lnws_pkg::DIVN_W-1:0]   quo;
  logic [lnws_pkg::DIVD_W:0]     trial;
  logic                          fits;

  assign trial    = {rem, quo[lnws_pkg::DIVN_W-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(lnws_pkg::DIVN_W);
        rem  <= '0;
        dsr  <= divisor;
        quo  <= dividend;
      end else if (busy) begin
        if (fits) begin
          rem <= lnws_pkg::DIVD_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[lnws_pkg::DIVD_W-1:0];
        end
        quo <= {quo[lnws_pkg::DIVN_W-2:0], fits};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/lnws_lane.sv
// ----------------------------------------------------------------------------
// lnws_lane
// One channel lane: row and scale memories, squared deviation and scaled
// normalized output pipeline.
// ----------------------------------------------------------------------------
module lnws_lane (
  input  logic                               clk,
  input  lnws_pkg::lane_ctrl_t               ctrl,
  input  logic [lnws_pkg::DATA_W-1:0]        wr_data,
  input  logic signed [lnws_pkg::MEAN_W-1:0] mean,
  input  logic [lnws_pkg::INV_W-1:0]         invstd,
  output logic [lnws_pkg::SQ_W-1:0]          sq,
  output logic [lnws_pkg::DATA_W-1:0]        o
);

  localparam int HALF = lnws_pkg::INV_W / 2;

  logic [lnws_pkg::DATA_W-1:0] row_mem   [lnws_pkg::MAX_GROUPS];
  logic [lnws_pkg::DATA_W-1:0] scale_mem [lnws_pkg::MAX_GROUPS];
  logic signed [lnws_pkg::DATA_W-1:0] x;
  logic signed [lnws_pkg::DATA_W-1:0] s;
  logic signed [17:0] d;
  logic signed [35:0] dd;
  logic signed [33:0] p1;
  logic signed [46:0] ph;
  logic signed [46:0] pl;
  logic signed [58:0] p;
  logic signed [58:0] pr;
  logic signed [30:0] q;

  always_ff @(posedge clk) begin
    if (ctrl.row_we) begin
      row_mem[ctrl.wr_addr] <= wr_data;
    end
    if (ctrl.scale_we) begin
      scale_mem[ctrl.wr_addr] <= wr_data;
    end
    x <= row_mem[ctrl.rd_addr];
    s <= scale_mem[ctrl.rd_addr];
  end

  assign d  = 18'(x) - 18'(mean);
  assign dd = d * d;
  assign p  = (59'(ph) <<< HALF) + 59'(pl);
  assign pr = p + (59'sd1 <<< 27);
  assign q  = 31'(pr >>> 28);

  always_ff @(posedge clk) begin
    sq <= dd[lnws_pkg::SQ_W-1:0];
    p1 <= d * 34'(s);
    ph <= p1 * $signed({1'b0, invstd[lnws_pkg::INV_W-1:HALF]});
    pl <= p1 * $signed({1'b0, invstd[HALF-1:0]});
    if (q > 31'sd32767) begin
      o <= 16'h7fff;
    end else if (q < -31'sd32768) begin
      o <= 16'h8000;
    end else begin
      o <= q[lnws_pkg::DATA_W-1:0];
    end
  end

endmodule

>>> sv/lnws_merge.sv
// ----------------------------------------------------------------------------
// lnws_merge
// Adds the squared deviations of all lanes and accumulates over the row.
// ----------------------------------------------------------------------------
module lnws_merge (
  input  logic                           clk,
  input  lnws_pkg::merge_ctrl_t          ctrl,
  input  lnws_pkg::sq_vec_t              sq,
  output logic [lnws_pkg::SUMSQ_W-1:0]   sumsq
);

  logic [lnws_pkg::SQ_W+3:0] tree;
  logic [lnws_pkg::SQ_W+3:0] tree_sum;

  always_comb begin
    tree_sum = '0;
    for (int i = 0; i < lnws_pkg::LANES; i++) begin
      tree_sum = tree_sum + (lnws_pkg::SQ_W+4)'(sq[i]);
    end
  end

  always_ff @(posedge clk) begin
    tree <= tree_sum;
    if (ctrl.clear) begin
      sumsq <= '0;
    end else if (ctrl.add) begin
      sumsq <= sumsq + lnws_pkg::SUMSQ_W'(tree);
    end
  end

endmodule

>>> sv/layer_norm_with_scale.sv
// ----------------------------------------------------------------------------
// layer_norm_with_scale
// Row layer normalization with per-channel scale, eight lanes wide.
// The work on a row of C groups runs in this order: mean divide,
// variance pass, variance divide, reciprocal divide, 24-step root, output pass.
// Results come out one group per cycle; start is ignored while busy is high.
// Reset clears control state; row and scale memories hold garbage until written.
// ----------------------------------------------------------------------------
module layer_norm_with_scale (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [lnws_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind,
  input  logic [lnws_pkg::GRP_W-1:0]         group_index,
  input  logic signed [15:0]                 v0,
  input  logic signed [15:0]                 v1,
  input  logic signed [15:0]                 v2,
  input  logic signed [15:0]                 v3,
  input  logic signed [15:0]                 v4,
  input  logic signed [15:0]                 v5,
  input  logic signed [15:0]                 v6,
  input  logic signed [15:0]                 v7,
  output logic                               result_valid,
  output logic [lnws_pkg::GRP_W-1:0]         out_group,
  output logic signed [15:0]                 o0,
  output logic signed [15:0]                 o1,
  output logic signed [15:0]                 o2,
  output logic signed [15:0]                 o3,
  output logic signed [15:0]                 o4,
  output logic signed [15:0]                 o5,
  output logic signed [15:0]                 o6,
  output logic signed [15:0]                 o7,
  output logic                               last_group
);

  localparam int CNT_W  = lnws_pkg::CNT_W;
  localparam int GRP_W  = lnws_pkg::GRP_W;
  localparam int INV_W  = lnws_pkg::INV_W;
  localparam int DIVN_W = lnws_pkg::DIVN_W;
  localparam int DIVD_W = lnws_pkg::DIVD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MEAN, S_MEAN_W, S_VAR, S_VAR_W, S_VDIV, S_VDIV_W,
    S_LDIV, S_LDIV_W, S_SQRT, S_OUT, S_OUT_W
  } state_t;

  state_t state;

  logic [6:0]                        row_groups;
  logic [lnws_pkg::EPS_W-1:0]        epsilon;
  logic [CNT_W-1:0]                  groups_received;
  logic signed [lnws_pkg::SUM_W-1:0] running_sum;
  logic [CNT_W-1:0]                  count;
  logic [GRP_W-1:0]                  rd_cnt;
  logic signed [lnws_pkg::MEAN_W-1:0] mean;
  logic                              mean_neg;
  logic [lnws_pkg::VAR_W-1:0]        v;
  logic [DIVN_W-1:0]                 lim;
  logic                              lim_max;
  logic [INV_W-1:0]                  r;
  logic [4:0]                        bit_idx;
  logic [3:1]                        vp;
  logic [4:1]                        op;
  logic [4:1][GRP_W-1:0]             grp_pipe;
  logic [4:1]                        last_pipe;

  lnws_pkg::data_vec_t               vin;
  lnws_pkg::data_vec_t               vout;
  lnws_pkg::sq_vec_t                 sq;
  lnws_pkg::lane_ctrl_t              lane_ctrl;
  lnws_pkg::merge_ctrl_t             merge_ctrl;
  logic [lnws_pkg::SUMSQ_W-1:0]      sumsq;

  logic                              accept;
  logic                              sample_acc;
  logic [CNT_W-1:0]                  eff;
  logic [CNT_W-1:0]                  gr_next;
  logic signed [lnws_pkg::SUM_W-1:0] sum_next;
  logic signed [26:0]                num;
  logic signed [23:0]                num8;
  logic [23:0]                       mag;
  logic                              var_issue;
  logic                              out_issue;
  logic                              last_issue;
  logic                              div_start;
  logic [DIVN_W-1:0]                 div_dividend;
  logic [DIVD_W-1:0]                 div_divisor;
  logic                              div_busy;
  logic                              div_done;
  logic [DIVN_W-1:0]                 div_q;
  logic [INV_W-1:0]                  cand;
  logic [2*INV_W-1:0]                cand_sq;
  logic [16:0]                       q17;

  assign vin = {v7, v6, v5, v4, v3, v2, v1, v0};
  assign {o7, o6, o5, o4, o3, o2, o1, o0} = vout;

  assign busy       = state != S_IDLE;
  assign accept     = start && !busy;
  assign sample_acc = accept && kind == lnws_pkg::KIND_SAMPLE;

  always_comb begin
    if (row_groups == 7'd0) begin
      eff = CNT_W'(1);
    end else if (row_groups > CNT_W'(lnws_pkg::MAX_GROUPS)) begin
      eff = CNT_W'(lnws_pkg::MAX_GROUPS);
    end else begin
      eff = row_groups;
    end
    sum_next = running_sum;
    for (int i = 0; i < lnws_pkg::LANES; i++) begin
      sum_next = sum_next + lnws_pkg::SUM_W'($signed(vin[i]));
    end
  end

  assign gr_next = groups_received + CNT_W'(1);

  assign num  = 27'(running_sum) + 27'({count, 2'b00});
  assign num8 = 24'(num >>> 3);
  assign mag  = num8[23] ? 24'(-num8) + 24'(count) - 24'd1 : num8;

  assign last_issue = CNT_W'(rd_cnt) == count - CNT_W'(1);
  assign var_issue  = state == S_VAR;
  assign out_issue  = state == S_OUT;

  assign lane_ctrl.row_we   = sample_acc;
  assign lane_ctrl.scale_we = accept && kind == lnws_pkg::KIND_SCALE;
  assign lane_ctrl.wr_addr  = (kind == lnws_pkg::KIND_SCALE) ? group_index
                                                             : groups_received[GRP_W-1:0];
  assign lane_ctrl.rd_addr  = rd_cnt;

  assign merge_ctrl.clear = state == S_MEAN;
  assign merge_ctrl.add   = vp[3];

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = DIVD_W'(count);
    case (state)
      S_MEAN: begin
        div_start    = 1'b1;
        div_dividend = DIVN_W'(mag);
      end
      S_VDIV: begin
        div_start    = 1'b1;
        div_dividend = DIVN_W'(sumsq >> 3);
      end
      S_LDIV: begin
        div_start    = v != '0;
        div_dividend = DIVN_W'(1) << 48;
        div_divisor  = v;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign cand    = r | (INV_W'(1) << bit_idx);
  assign cand_sq = cand * cand;
  assign q17     = div_q[16:0];

  lnws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  for (genvar l = 0; l < lnws_pkg::LANES; l++) begin : g_lane
    lnws_lane u_lane (
      .clk     (clk),
      .ctrl    (lane_ctrl),
      .wr_data (vin[l]),
      .mean    (mean),
      .invstd  (r),
      .sq      (sq[l]),
      .o       (vout[l])
    );
  end

  lnws_merge u_merge (
    .clk   (clk),
    .ctrl  (merge_ctrl),
    .sq    (sq),
    .sumsq (sumsq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      row_groups      <= lnws_pkg::RG_RESET;
      epsilon         <= lnws_pkg::EPS_RESET;
      groups_received <= '0;
      running_sum     <= '0;
      vp              <= '0;
      op              <= '0;
      rd_cnt          <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lnws_pkg::CFG_ROW_GROUPS: row_groups <= cfg_data[6:0];
          lnws_pkg::CFG_EPSILON:    epsilon    <= cfg_data;
          default:                  epsilon    <= epsilon;
        endcase
      end
      vp        <= {vp[2:1], var_issue};
      op        <= {op[3:1], out_issue};
      grp_pipe  <= {grp_pipe[3:1], rd_cnt};
      last_pipe <= {last_pipe[3:1], last_issue};
      case (state)
        S_IDLE: begin
          if (sample_acc) begin
            running_sum <= sum_next;
            if (gr_next >= eff) begin
              count           <= gr_next;
              groups_received <= '0;
              state           <= S_MEAN;
            end else begin
              groups_received <= gr_next;
            end
          end
        end
        S_MEAN: begin
          mean_neg    <= num8[23];
          running_sum <= '0;
          state       <= S_MEAN_W;
        end
        S_MEAN_W: begin
          if (div_done) begin
            mean   <= mean_neg ? -$signed(q17) : $signed(q17);
            rd_cnt <= '0;
            state  <= S_VAR;
          end
        end
        S_VAR: begin
          rd_cnt <= rd_cnt + GRP_W'(1);
          if (last_issue) begin
            state <= S_VAR_W;
          end
        end
        S_VAR_W: begin
          if (vp == '0) begin
            state <= S_VDIV;
          end
        end
        S_VDIV: begin
          state <= S_VDIV_W;
        end
        S_VDIV_W: begin
          if (div_done) begin
            v     <= lnws_pkg::VAR_W'(div_q[31:0]) + lnws_pkg::VAR_W'(epsilon);
            state <= S_LDIV;
          end
        end
        S_LDIV: begin
          lim_max <= v == '0;
          r       <= '0;
          bit_idx <= 5'(INV_W - 1);
          state   <= (v == '0) ? S_SQRT : S_LDIV_W;
        end
        S_LDIV_W: begin
          if (div_done) begin
            lim   <= div_q;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (lim_max || DIVN_W'(cand_sq) <= lim) begin
            r <= cand;
          end
          bit_idx <= bit_idx - 5'd1;
          if (bit_idx == 5'd0) begin
            rd_cnt <= '0;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          rd_cnt <= rd_cnt + GRP_W'(1);
          if (last_issue) begin
            state <= S_OUT_W;
          end
        end
        S_OUT_W: begin
          if (op == '0) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid = op[4];
  assign out_group    = grp_pipe[4];
  assign last_group   = last_pipe[4];

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe outside of a row pass");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_group |=> !result_valid)
    else $error("result after the last group of a row");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_no_issue_in_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> !var_issue && !out_issue)
    else $error("memory read issued while taking input");

endmodule
